@@ hdl/ttsi_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the text-to-signed-integer parser.
// Used by the front end, the queue and the back end; depends on nothing.
package ttsi_pkg;

    localparam int QDEPTH = 4;

    localparam logic [5:0] BASE_MAX   = 6'd36;
    localparam logic [5:0] BASE_OCT   = 6'd8;
    localparam logic [5:0] BASE_DEC   = 6'd10;
    localparam logic [5:0] BASE_HEX   = 6'd16;
    localparam logic [5:0] BASE_BAD   = 6'd1;
    localparam logic [5:0] BASE_AUTO  = 6'd0;
    localparam logic [5:0] DIGIT_NONE = 6'd36;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [63:0] INT64_MAX_BITS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN_BITS = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_NODIGITS = 2'd2,
        ST_BADBASE  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_LEAD     = 3'd1,
        PH_SIGNED   = 3'd2,
        PH_ZERO     = 3'd3,
        PH_HEXFIRST = 3'd4,
        PH_DIGITS   = 3'd5
    } t_phase;

    typedef struct packed {
        logic       first;
        logic [5:0] base;
        logic [5:0] digit;
        logic       is_space;
        logic       is_plus;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
    } t_entry;

endpackage

@@ hdl/ttsi_in_if.sv @@
`timescale 1ns / 1ps
// Character request channel of the parser.
// Standalone; carries valid, ready, one string byte and its first-of-string flag.
interface ttsi_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       first_of_string;

    modport source (output valid, output char_code, output first_of_string, input ready);
    modport sink   (input valid, input char_code, input first_of_string, output ready);
endinterface

@@ hdl/ttsi_out_if.sv @@
`timescale 1ns / 1ps
// Result request channel of the parser.
// Standalone; carries valid, ready, value, status and end index.
interface ttsi_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic [1:0]         status;
    logic [15:0]        end_index;

    modport source (output valid, output value, output status, output end_index, input ready);
    modport sink   (input valid, input value, input status, input end_index, output ready);
endinterface

@@ hdl/ttsi_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel of the parser.
// Standalone; carries valid, ready and the base setting.
interface ttsi_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] base_setting;

    modport source (output valid, output base_setting, input ready);
    modport sink   (input valid, input base_setting, output ready);
endinterface

@@ hdl/ttsi_front.sv @@
`timescale 1ns / 1ps
// Front end: holds the base register, accepts characters and classifies them.
// Depends on ttsi_pkg, ttsi_in_if and ttsi_cfg_if.
module ttsi_front
    import ttsi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttsi_in_if.sink    i_char,
    ttsi_cfg_if.sink   i_cfg,
    input  logic       i_q_ready,
    output logic       o_q_push,
    output t_entry     o_q_entry
);

    logic [5:0] r_base;
    logic [7:0] c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_AUTO;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_base <= i_cfg.base_setting;
        end
    end

    assign i_cfg.ready  = 1'b1;
    assign i_char.ready = i_q_ready;
    assign o_q_push     = i_char.valid && i_q_ready;
    assign c            = i_char.char_code;

    always_comb begin
        o_q_entry.first    = i_char.first_of_string;
        o_q_entry.base     = r_base;
        o_q_entry.is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        o_q_entry.is_plus  = (c == CH_PLUS);
        o_q_entry.is_minus = (c == CH_MINUS);
        o_q_entry.is_zero  = (c == CH_ZERO);
        o_q_entry.is_x     = (c == CH_LX) || (c == CH_UX);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            o_q_entry.digit = 6'(c - CH_ZERO);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            o_q_entry.digit = 6'(c - CH_LA + 8'd10);
        end else if (c >= CH_UA && c <= CH_UZ) begin
            o_q_entry.digit = 6'(c - CH_UA + 8'd10);
        end else begin
            o_q_entry.digit = DIGIT_NONE;
        end
    end

endmodule

@@ hdl/ttsi_queue.sv @@
`timescale 1ns / 1ps
// Short queue between the front and back ends of the parser.
// Depends on ttsi_pkg for the entry type and depth.
module ttsi_queue
    import ttsi_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_ready,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_entry         r_mem [QDEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_ready = (r_count != CW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/ttsi_back.sv @@
`timescale 1ns / 1ps
// Back end: parse state machine, accumulator and result register.
// Depends on ttsi_pkg and ttsi_out_if.
module ttsi_back
    import ttsi_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_entry     i_q_entry,
    output logic       o_q_pop,
    ttsi_out_if.source o_result
);

    t_phase                   r_phase, n_phase;
    logic [63:0]              r_acc, n_acc;
    logic                     r_neg, n_neg;
    logic                     r_ovf, n_ovf;
    logic [5:0]               r_rb, n_rb;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_pfx, n_pfx;

    logic                     r_out_valid;
    logic [63:0]              r_out_value;
    t_status                  r_out_status;
    logic [15:0]              r_out_index;

    logic                     pop;
    logic                     emit;
    logic                     emit_fin;
    t_status                  emit_status;
    logic [POSITION_BITS-1:0] emit_pos;
    logic                     acc_req;
    logic                     after_sign;
    logic [POSITION_BITS-1:0] cur_pos;
    logic [5:0]               eff_b;
    logic [69:0]              prod;
    logic [63:0]              d_value;
    t_status                  d_status;
    logic [15:0]              d_index;
    t_entry                   e;

    assign e       = i_q_entry;
    assign pop     = i_q_valid && (!r_out_valid || o_result.ready);
    assign o_q_pop = pop;

    // next state and datapath
    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_ovf       = r_ovf;
        n_rb        = r_rb;
        n_pos       = r_pos;
        n_pfx       = r_pfx;
        emit        = 1'b0;
        emit_fin    = 1'b0;
        emit_status = ST_OK;
        emit_pos    = '0;
        acc_req     = 1'b0;
        after_sign  = 1'b0;
        cur_pos     = r_pos;
        eff_b       = r_rb;
        prod        = '0;
        if (pop) begin
            if (e.first) begin
                n_phase = PH_LEAD;
                n_acc   = '0;
                n_neg   = 1'b0;
                n_ovf   = 1'b0;
                n_pos   = '0;
                n_pfx   = '0;
                n_rb    = e.base;
                if (e.base == BASE_BAD || e.base > BASE_MAX) begin
                    emit        = 1'b1;
                    emit_status = ST_BADBASE;
                    n_phase     = PH_IDLE;
                end
            end
            if (n_phase != PH_IDLE) begin
                cur_pos = n_pos;
                n_pos   = cur_pos + 1'b1;
                case (n_phase)
                    PH_LEAD: begin
                        if (e.is_space) begin
                            n_phase = PH_LEAD;
                        end else if (e.is_plus || e.is_minus) begin
                            n_neg   = e.is_minus;
                            n_phase = PH_SIGNED;
                        end else begin
                            after_sign = 1'b1;
                        end
                    end
                    PH_SIGNED: begin
                        after_sign = 1'b1;
                    end
                    PH_ZERO: begin
                        if (e.is_x) begin
                            n_rb    = BASE_HEX;
                            n_phase = PH_HEXFIRST;
                        end else begin
                            if (n_rb == BASE_AUTO) begin
                                n_rb = BASE_OCT;
                            end
                            n_acc   = '0;
                            n_phase = PH_DIGITS;
                            if (e.digit < n_rb) begin
                                acc_req = 1'b1;
                            end else begin
                                emit     = 1'b1;
                                emit_fin = 1'b1;
                                emit_pos = cur_pos;
                            end
                        end
                    end
                    PH_HEXFIRST: begin
                        if (e.digit < BASE_HEX) begin
                            acc_req = 1'b1;
                            n_phase = PH_DIGITS;
                        end else begin
                            emit        = 1'b1;
                            emit_status = ST_OK;
                            emit_pos    = n_pfx;
                        end
                    end
                    PH_DIGITS: begin
                        if (e.digit < n_rb) begin
                            acc_req = 1'b1;
                        end else begin
                            emit     = 1'b1;
                            emit_fin = 1'b1;
                            emit_pos = cur_pos;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
                if (after_sign) begin
                    if (e.is_zero && (n_rb == BASE_AUTO || n_rb == BASE_HEX)) begin
                        n_pfx   = cur_pos + 1'b1;
                        n_phase = PH_ZERO;
                    end else begin
                        if (n_rb == BASE_AUTO) begin
                            n_rb = BASE_DEC;
                        end
                        if (e.digit < n_rb) begin
                            acc_req = 1'b1;
                            n_phase = PH_DIGITS;
                        end else begin
                            emit        = 1'b1;
                            emit_status = ST_NODIGITS;
                        end
                    end
                end
                eff_b = n_rb;
                if (acc_req && !n_ovf) begin
                    prod = 70'(n_acc) * 70'(eff_b) + 70'(e.digit);
                    if (prod[69:63] != '0) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = prod[63:0];
                    end
                end
                if (emit) begin
                    n_phase = PH_IDLE;
                end
            end
        end
    end

    // result fields
    always_comb begin
        d_index = 16'(emit_pos);
        if (!emit_fin) begin
            d_value  = '0;
            d_status = emit_status;
        end else if (n_ovf) begin
            d_value  = n_neg ? INT64_MIN_BITS : INT64_MAX_BITS;
            d_status = ST_OVERFLOW;
        end else begin
            d_value  = n_neg ? (64'd0 - n_acc) : n_acc;
            d_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_ovf       <= 1'b0;
            r_rb        <= '0;
            r_pos       <= '0;
            r_pfx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_ovf   <= n_ovf;
            r_rb    <= n_rb;
            r_pos   <= n_pos;
            r_pfx   <= n_pfx;
            if (pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_out_value  <= d_value;
            r_out_status <= d_status;
            r_out_index  <= d_index;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.value     = $signed(r_out_value);
    assign o_result.status    = r_out_status;
    assign o_result.end_index = r_out_index;

    a_acc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_acc[63])
        else $error("accumulator exceeds signed maximum");

    a_idle_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && emit) |=> (r_phase == PH_IDLE) && r_out_valid)
        else $error("parser not idle after result");

    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_OVERFLOW) |->
        (r_out_value == INT64_MAX_BITS || r_out_value == INT64_MIN_BITS))
        else $error("overflow result not saturated");

    a_no_pop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !o_q_pop)
        else $error("queue popped while result stalled");

endmodule

@@ hdl/text_to_signed_integer_parser.sv @@
`timescale 1ns / 1ps
// Streaming text-to-signed-integer parser, bases 2 to 36 or auto-detected.
// Channels: i_char takes one string byte per request, first_of_string set on
// the first byte; o_result gives value, status and end index once per string;
// i_cfg writes the base setting, which is latched when a string starts and is
// always ready.
// Throughput: one byte per cycle while o_result does not stall. The front end
// classifies a byte in the cycle it is accepted and pushes it into a four-entry
// queue; the back end retires one queued byte per cycle through its
// multiply-accumulate and state machine. The result of a terminating byte passes
// through the queue write, then the result register, before it is valid.
// Reset (synchronous, active low) empties the queue, clears the result
// valid flag, sets the parser idle and the base setting to auto-detect.
// When o_result stalls, the back end holds the pending result and stops
// draining the queue; i_char keeps accepting until the queue fills.
// Depends on ttsi_pkg, the channel interfaces, ttsi_front, ttsi_queue, ttsi_back.
module text_to_signed_integer_parser
    import ttsi_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttsi_in_if.sink    i_char,
    ttsi_cfg_if.sink   i_cfg,
    ttsi_out_if.source o_result
);

    logic   q_push;
    logic   q_ready;
    logic   q_pop;
    logic   q_valid;
    t_entry q_in;
    t_entry q_out;

    ttsi_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char    (i_char),
        .i_cfg     (i_cfg),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_entry (q_in)
    );

    ttsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    ttsi_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_out),
        .o_q_pop   (q_pop),
        .o_result  (o_result)
    );

endmodule
